@@ design/circle_mask_span_generator_macros.svh @@
// Assertion macros shared by the circle mask span generator RTL.
// Needs nothing else; files that assert take it by `include.
`ifndef CIRCLE_MASK_SPAN_GENERATOR_MACROS_SVH
`define CIRCLE_MASK_SPAN_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CMSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CMSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cmsg_pkg.sv @@
// Shared types and constants of the circle mask span generator.
// No dependencies; every RTL file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cmsg_pkg;

    localparam int CX_W   = 11;   // centre coordinates and loop coordinates
    localparam int RAD_W  = 9;
    localparam int DEC_W  = 14;   // midpoint decision value
    localparam int CRD_W  = 12;   // result coordinates
    localparam int DIM_W  = 11;   // screen width and height
    localparam int COL_W  = 24;
    localparam int KIND_W = 2;

    localparam logic [RAD_W:0]   MAX_RADIUS = 10'd511;
    localparam logic [DEC_W-1:0] DEC_INIT   = 14'd3;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [KIND_W-1:0] SHAPE_BOX  = 2'd0;
    localparam logic [KIND_W-1:0] SHAPE_LINE = 2'd1;
    localparam logic [KIND_W-1:0] SHAPE_IDLE = 2'd2;

    localparam logic REQ_START = 1'b0;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILL_COLOR    = 2'd2;

    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 11'd480;
    localparam logic [COL_W-1:0] FILL_COLOR_RST    = 24'd0;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_STEP,
        MODE_IDLE
    } mode_t;

    // One classified request: centre, pre-update loop coordinates and flags.
    typedef struct packed {
        mode_t            mode;
        logic [CX_W-1:0]  cx;
        logic [CX_W-1:0]  cy;
        logic [CX_W-1:0]  pa;    // span_dx before the update (radius on start)
        logic [CX_W-1:0]  pb;    // span_dy before the update
        logic             adv;   // decision was non-negative: four more lines
        logic             done;  // loop finished after this request
    } job_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CRD_W-1:0]  xa;
        logic [CRD_W-1:0]  ya;
        logic [CRD_W-1:0]  xb;
        logic [CRD_W-1:0]  yb;
        logic [COL_W-1:0]  color;
        logic              last;
        logic              done;
    } result_t;

endpackage

`default_nettype wire

@@ design/cmsg_job_queue.sv @@
// Small FIFO of classified requests between the front and back parts.
// Depends on cmsg_pkg for job_t and the depth.
`timescale 1ns / 1ps
`default_nettype none

module cmsg_job_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  cmsg_pkg::job_t  wr_job,
    output logic            full,
    input  logic            rd_en,
    output cmsg_pkg::job_t  rd_job,
    output logic            empty
);

    cmsg_pkg::job_t mem_reg [cmsg_pkg::QDEPTH];

    logic [cmsg_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cmsg_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cmsg_pkg::QPTR_W:0]   cnt_reg, cnt_next;

    assign full   = (cnt_reg == (cmsg_pkg::QPTR_W + 1)'(cmsg_pkg::QDEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

@@ design/cmsg_front.sv @@
// Front part: accepts requests, runs the midpoint state update, classifies.
// Depends on cmsg_pkg; feeds cmsg_job_queue.
`timescale 1ns / 1ps
`default_nettype none

module cmsg_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           req_type,
    input  logic [cmsg_pkg::CX_W-1:0]      center_x,
    input  logic [cmsg_pkg::CX_W-1:0]      center_y,
    input  logic [cmsg_pkg::RAD_W-1:0]     radius,
    output cmsg_pkg::job_t                 job
);

    logic [cmsg_pkg::CX_W-1:0]  dx_reg, dx_next;
    logic [cmsg_pkg::CX_W-1:0]  dy_reg, dy_next;
    logic [cmsg_pkg::DEC_W-1:0] dec_reg, dec_next;
    logic [cmsg_pkg::CX_W-1:0]  cx_reg, cx_next;
    logic [cmsg_pkg::CX_W-1:0]  cy_reg, cy_next;
    logic                       run_reg, run_next;

    logic [cmsg_pkg::RAD_W-1:0] r_sat;
    logic                       is_start;
    logic                       active;
    logic [cmsg_pkg::CX_W-1:0]  cx_b, cy_b, dx0, dy0, dx1, dy1;
    logic [cmsg_pkg::DEC_W-1:0] d0, d1, d2;
    logic                       adv;
    logic                       run1;

    always_comb
    begin
        r_sat    = ({1'b0, radius} > cmsg_pkg::MAX_RADIUS)
                   ? cmsg_pkg::MAX_RADIUS[cmsg_pkg::RAD_W-1:0] : radius;
        is_start = (req_type == cmsg_pkg::REQ_START);
        active   = is_start || run_reg;

        if (is_start)
        begin
            cx_b = center_x;
            cy_b = center_y;
            dx0  = {{(cmsg_pkg::CX_W - cmsg_pkg::RAD_W){1'b0}}, r_sat};
            dy0  = '0;
            d0   = cmsg_pkg::DEC_INIT
                   - {{(cmsg_pkg::DEC_W - cmsg_pkg::RAD_W - 1){1'b0}}, r_sat, 1'b0};
        end
        else
        begin
            cx_b = cx_reg;
            cy_b = cy_reg;
            dx0  = dx_reg;
            dy0  = dy_reg;
            d0   = dec_reg;
        end

        // One midpoint update: optional x decrement, then y increment
        adv  = !d0[cmsg_pkg::DEC_W-1];
        dx1  = adv ? (dx0 - 1'b1) : dx0;
        d1   = adv ? (d0 - {dx1[cmsg_pkg::CX_W-1], dx1, 2'b00}) : d0;
        dy1  = dy0 + 1'b1;
        d2   = d1 + {dy1[cmsg_pkg::CX_W-1], dy1, 2'b10};
        run1 = ($signed(dx1) >= $signed(dy1));

        job.mode = is_start ? cmsg_pkg::MODE_START
                 : (run_reg ? cmsg_pkg::MODE_STEP : cmsg_pkg::MODE_IDLE);
        job.cx   = cx_b;
        job.cy   = cy_b;
        job.pa   = dx0;
        job.pb   = dy0;
        job.adv  = adv;
        job.done = active ? !run1 : 1'b1;

        dx_next  = dx_reg;
        dy_next  = dy_reg;
        dec_next = dec_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        run_next = run_reg;
        if (accept && active)
        begin
            dx_next  = dx1;
            dy_next  = dy1;
            dec_next = d2;
            cx_next  = cx_b;
            cy_next  = cy_b;
            run_next = run1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg  <= '0;
            dy_reg  <= '0;
            dec_reg <= '0;
            cx_reg  <= '0;
            cy_reg  <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dec_reg <= dec_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            run_reg <= run_next;
        end
    end

endmodule

`default_nettype wire

@@ design/cmsg_back.sv @@
// Back part: expands queued requests into boxes, lines and idle results, one per cycle
// while the output register is free or popped, into that register. Depends on cmsg_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "circle_mask_span_generator_macros.svh"

module cmsg_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  cmsg_pkg::job_t                 q_job,
    output logic                           q_pop,
    input  logic [cmsg_pkg::DIM_W-1:0]     screen_width,
    input  logic [cmsg_pkg::DIM_W-1:0]     screen_height,
    input  logic [cmsg_pkg::COL_W-1:0]     fill_color,
    input  logic                           pop,
    output cmsg_pkg::result_t              res,
    output logic                           res_valid
);

    cmsg_pkg::job_t    job_reg, job_next;
    logic              busy_reg, busy_next;
    logic [2:0]        cnt_reg, cnt_next;
    cmsg_pkg::result_t res_reg, res_next;
    logic              ovalid_reg, ovalid_next;

    logic                      ld;
    logic                      emit;
    logic                      is_last;
    logic                      load;
    logic [cmsg_pkg::CRD_W-1:0] cx, cy, pa, pb, w, h;
    logic [cmsg_pkg::CRD_W-1:0] row_off, span_off, row, xl, xr;
    logic [cmsg_pkg::CRD_W-1:0] x_m_r, x_p_r, y_m_r, y_p_r1;

    assign res       = res_reg;
    assign res_valid = ovalid_reg;

    always_comb
    begin
        cx = {job_reg.cx[cmsg_pkg::CX_W-1], job_reg.cx};
        cy = {job_reg.cy[cmsg_pkg::CX_W-1], job_reg.cy};
        pa = {job_reg.pa[cmsg_pkg::CX_W-1], job_reg.pa};
        pb = {job_reg.pb[cmsg_pkg::CX_W-1], job_reg.pb};
        w  = {1'b0, screen_width};
        h  = {1'b0, screen_height};

        // Bounding boxes of a new circle
        x_m_r  = cx - pa;
        x_p_r  = cx + pa;
        y_m_r  = cy - pa;
        y_p_r1 = cy + pa + 1'b1;

        // First group: rows at span_dy, second group: rows at span_dx
        row_off  = cnt_reg[2] ? pa : pb;
        span_off = cnt_reg[2] ? pb : pa;
        row      = cnt_reg[1] ? (cy - row_off) : (cy + row_off);
        xl       = cx - span_off;
        xr       = cx + span_off;

        ld      = !ovalid_reg || pop;
        emit    = busy_reg && ld;
        is_last = (job_reg.mode == cmsg_pkg::MODE_IDLE) || (cnt_reg == 3'd7)
                  || ((cnt_reg == 3'd3) && !job_reg.adv);
        load    = (!busy_reg || (emit && is_last)) && !q_empty;
        q_pop   = load;

        res_next       = res_reg;
        res_next.color = fill_color;
        res_next.last  = is_last;
        res_next.done  = job_reg.done;
        if (job_reg.mode == cmsg_pkg::MODE_IDLE)
        begin
            res_next.kind = cmsg_pkg::SHAPE_IDLE;
            res_next.xa   = '0;
            res_next.ya   = '0;
            res_next.xb   = '0;
            res_next.yb   = '0;
        end
        else if ((job_reg.mode == cmsg_pkg::MODE_START) && !cnt_reg[2])
        begin
            res_next.kind = cmsg_pkg::SHAPE_BOX;
            unique case (cnt_reg[1:0])
                2'd0:
                begin
                    res_next.xa = '0;
                    res_next.ya = '0;
                    res_next.xb = w;
                    res_next.yb = y_m_r;
                end
                2'd1:
                begin
                    res_next.xa = '0;
                    res_next.ya = y_m_r;
                    res_next.xb = x_m_r;
                    res_next.yb = h;
                end
                2'd2:
                begin
                    res_next.xa = x_m_r;
                    res_next.ya = y_p_r1;
                    res_next.xb = w;
                    res_next.yb = h;
                end
                default:
                begin
                    res_next.xa = x_p_r;
                    res_next.ya = y_m_r;
                    res_next.xb = w;
                    res_next.yb = y_p_r1;
                end
            endcase
        end
        else
        begin
            res_next.kind = cmsg_pkg::SHAPE_LINE;
            res_next.ya   = row;
            res_next.yb   = row;
            if (cnt_reg[0])
            begin
                res_next.xa = xr;
                res_next.xb = w;
            end
            else
            begin
                res_next.xa = '0;
                res_next.xb = xl;
            end
        end

        ovalid_next = ld ? emit : ovalid_reg;

        job_next  = load ? q_job : job_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (emit)
        begin
            cnt_next = is_last ? 3'd0 : (cnt_reg + 1'b1);
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    `CMSG_ASSERT_NOW(a_second_group_needs_adv, clk, rst_n,
        busy_reg && cnt_reg[2], job_reg.adv, "second line group without decision step")
    `CMSG_ASSERT_NOW(a_idle_single, clk, rst_n,
        busy_reg && (job_reg.mode == cmsg_pkg::MODE_IDLE), cnt_reg == 3'd0,
        "idle request past its only result")
    `CMSG_ASSERT_NEXT(a_drain_to_idle, clk, rst_n,
        emit && is_last && q_empty, !busy_reg, "back part busy with no request")

endmodule

`default_nettype wire

@@ design/circle_mask_span_generator.sv @@
// Top level of the circle mask span generator: APB registers, front, queue, back.
// Depends on cmsg_pkg, cmsg_front, cmsg_job_queue and cmsg_back.
//
//  Channel    Handshake             Payload
//  request    push / full           req_type, center_x, center_y, radius
//  result     empty / pop           shape_kind, x_a, y_a, x_b, y_b, color, last, done_res
//  config     APB psel / penable    paddr, pwdata, prdata (screen_width, screen_height,
//                                   fill_color at 0x0, 0x4, 0x8)
//
//  A start request gives 4 boxes plus 4 lines when the decision is non-negative; a step
//  gives 4 or 8 lines; an idle step gives one result. Results leave at one per cycle,
//  set by the single output register, while the output is popped.
//  The front updates the loop state in the cycle of acceptance and queues up to 4
//  classified requests, so requests keep being taken while results stall until the
//  queue is full. A request passes through the queue and the back job register into
//  the output register. rst_n clears all control state and the registers to 640, 480 and 0.
`timescale 1ns / 1ps
`default_nettype none

module circle_mask_span_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            req_type,
    input  logic [cmsg_pkg::CX_W-1:0]       center_x,
    input  logic [cmsg_pkg::CX_W-1:0]       center_y,
    input  logic [cmsg_pkg::RAD_W-1:0]      radius,
    output logic                            empty,
    input  logic                            pop,
    output logic [cmsg_pkg::KIND_W-1:0]     shape_kind,
    output logic [cmsg_pkg::CRD_W-1:0]      x_a,
    output logic [cmsg_pkg::CRD_W-1:0]      y_a,
    output logic [cmsg_pkg::CRD_W-1:0]      x_b,
    output logic [cmsg_pkg::CRD_W-1:0]      y_b,
    output logic [cmsg_pkg::COL_W-1:0]      color,
    output logic                            last,
    output logic                            done_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cmsg_pkg::PADDR_W-1:0]    paddr,
    input  logic [cmsg_pkg::PDATA_W-1:0]    pwdata,
    output logic [cmsg_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    logic [cmsg_pkg::DIM_W-1:0] width_reg, width_next;
    logic [cmsg_pkg::DIM_W-1:0] height_reg, height_next;
    logic [cmsg_pkg::COL_W-1:0] color_reg, color_next;

    logic              cfg_wr;
    logic              accept;
    cmsg_pkg::job_t    front_job;
    cmsg_pkg::job_t    q_job;
    logic              q_empty;
    logic              q_pop;
    cmsg_pkg::result_t res;
    logic              res_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = push && !full;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        color_next  = color_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                cmsg_pkg::REG_SCREEN_WIDTH:  width_next  = pwdata[cmsg_pkg::DIM_W-1:0];
                cmsg_pkg::REG_SCREEN_HEIGHT: height_next = pwdata[cmsg_pkg::DIM_W-1:0];
                cmsg_pkg::REG_FILL_COLOR:    color_next  = pwdata[cmsg_pkg::COL_W-1:0];
                default: ;
            endcase
        end

        unique case (paddr[3:2])
            cmsg_pkg::REG_SCREEN_WIDTH:
                prdata = {{(cmsg_pkg::PDATA_W - cmsg_pkg::DIM_W){1'b0}}, width_reg};
            cmsg_pkg::REG_SCREEN_HEIGHT:
                prdata = {{(cmsg_pkg::PDATA_W - cmsg_pkg::DIM_W){1'b0}}, height_reg};
            cmsg_pkg::REG_FILL_COLOR:
                prdata = {{(cmsg_pkg::PDATA_W - cmsg_pkg::COL_W){1'b0}}, color_reg};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cmsg_pkg::SCREEN_WIDTH_RST;
            height_reg <= cmsg_pkg::SCREEN_HEIGHT_RST;
            color_reg  <= cmsg_pkg::FILL_COLOR_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            color_reg  <= color_next;
        end
    end

    cmsg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .job      (front_job)
    );

    cmsg_job_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_job (front_job),
        .full   (full),
        .rd_en  (q_pop),
        .rd_job (q_job),
        .empty  (q_empty)
    );

    cmsg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_job         (q_job),
        .q_pop         (q_pop),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .fill_color    (color_reg),
        .pop           (pop),
        .res           (res),
        .res_valid     (res_valid)
    );

    assign empty      = !res_valid;
    assign shape_kind = res.kind;
    assign x_a        = res.xa;
    assign y_a        = res.ya;
    assign x_b        = res.xb;
    assign y_b        = res.yb;
    assign color      = res.color;
    assign last       = res.last;
    assign done_res   = res.done;

endmodule

`default_nettype wire
